// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file mfq_checker.sv.
// Each macro expands to one labeled concurrent assertion on the clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define MFQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Implication checked at every rising clock edge, reset included.
`define MFQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== rtl/core/mfq_pkg.sv =====
// Package for the multilevel feedback queue: payload types and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfq_pkg;
   localparam int TID_W   = 6;
   localparam int PRIO_W  = 2;
   localparam int SVC_W   = 32;
   localparam int SLICE_W = 10;
   localparam int LVLO_W  = 4;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_SELECT  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [TID_W-1:0]  thread_id;
      logic [PRIO_W-1:0] priority_req;
      logic [SVC_W-1:0]  svc_ticks;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [TID_W-1:0]   chosen_thread;
      logic [SLICE_W-1:0] slice_ticks;
      logic [LVLO_W-1:0]  chosen_level;
      logic [PRIO_W-1:0]  chosen_priority;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/mfq_req_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on mfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mfq_req_if import mfq_pkg::*; ;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mfq_rsp_if import mfq_pkg::*; ;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/multilevel_feedback_queue.sv =====
// Multilevel feedback queue scheduler: per-thread memory plus per-list head/tail memory.
// Depends on mfq_pkg and the channel interfaces in mfq_req_if.sv.
//
// Usage: req carries enqueue beats (action 0) and select beats (action 1).
// An enqueue produces no rsp beat; a select produces exactly one rsp beat with
// the head of the first non-empty level, lowest class first, and slice 2^level.
// An item passes through the IDLE, READ and WRITE states. The accepting edge
// reads the thread entry and the head and tail of the first nonempty list; the
// READ edge reads the link of that head (select) or the tail of the target
// list, whose index depends on the thread's new level (enqueue); the WRITE
// edge writes everything back and registers a select result for rsp. A new
// request is accepted only in IDLE, so items do not overlap.
// Reset clears seen flags, queued flags and list nonempty bits at once; no
// clearing pass is needed. The memories themselves hold undefined data until
// written. When rsp stalls, the result waits in the output register; a new
// request is accepted while it waits, but a select is held until the output
// register is free.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_queue import mfq_pkg::*; #(
   parameter int NUM_LEVELS   = 10,
   parameter int NUM_CLASSES  = 4,
   parameter int THREAD_SLOTS = 64
) (
   input  wire      clock,
   input  wire      reset,
   mfq_req_if.sink  req,
   mfq_rsp_if.source rsp
);
   localparam int NL  = NUM_LEVELS * NUM_CLASSES;
   localparam int SW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int LW  = $clog2(NUM_LEVELS);
   localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int QW  = $clog2(NL);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   // Thread memory: runtime, last service, level; link memory; list head/tail memory.
   logic [SVC_W-1:0] run_mem [THREAD_SLOTS];
   logic [SVC_W-1:0] last_mem [THREAD_SLOTS];
   logic [LW-1:0]    lvl_mem [THREAD_SLOTS];
   logic [SW-1:0]    link_mem [THREAD_SLOTS];
   logic [SW-1:0]    head_mem [NL];
   logic [SW-1:0]    tail_mem [NL];

   logic [THREAD_SLOTS-1:0] seen_ff, seen_in, queued_ff, queued_in;
   logic [NL-1:0]           ne_ff, ne_in;
   logic [1:0]              state_ff, state_in;
   req_type                 cur_ff, cur_in;
   logic [QW-1:0]           sq_ff, sq_in;
   logic [LW-1:0]           sl_ff, sl_in;
   logic [CW-1:0]           sc_ff, sc_in;
   logic                    rv_ff, rv_in;
   rsp_type                 rsp_ff, rsp_in;

   // Registered memory read data.
   logic [SVC_W-1:0] run_rd, last_rd;
   logic [LW-1:0]    lvl_rd;
   logic [SW-1:0]    head_rd, tail_rd, link_rd;

   logic [SW-1:0] slot_r;
   logic          accept;
   logic [QW-1:0] first_q;
   logic [LW-1:0] first_lvl;
   logic [CW-1:0] first_cls;
   logic [QW-1:0] tail_addr;
   logic          tail_rd_en;

   logic [CW-1:0] ecls;
   logic [LW-1:0] elvl_old, elvl_new;
   logic [SVC_W-1:0] erun_sum, erun_new;
   logic [QW-1:0] eq;
   logic [SW-1:0] eslot;
   logic          eseen, ego;
   logic          drop;

   assign slot_r   = SW'(req.payload.thread_id);
   assign req.ready = (state_ff == ST_IDLE) &&
                      !(req.payload.action == ACT_SELECT && rv_ff && !rsp.ready);
   assign accept   = req.valid && req.ready;
   assign rsp.valid   = rv_ff;
   assign rsp.payload = rsp_ff;

   // Priority encode the first nonempty list (levels then classes in order).
   always_comb begin
      first_q   = '0;
      first_lvl = '0;
      first_cls = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (ne_ff[l * NUM_CLASSES + c]) begin
               first_q   = QW'(l * NUM_CLASSES + c);
               first_lvl = LW'(l);
               first_cls = CW'(c);
            end
         end
      end
   end

   // Enqueue list index; the thread read data holds from the accepting edge on.
   assign eslot = SW'(cur_ff.thread_id);
   always_comb begin
      if ({{(32-PRIO_W){1'b0}}, cur_ff.priority_req} >= 32'(NUM_CLASSES))
         ecls = CW'(NUM_CLASSES - 1);
      else
         ecls = CW'(cur_ff.priority_req);
      eseen    = seen_ff[eslot];
      ego      = ({{(32-TID_W){1'b0}}, cur_ff.thread_id} < 32'(THREAD_SLOTS)) &&
                 !queued_ff[eslot];
      erun_sum = run_rd + (cur_ff.svc_ticks - last_rd);
      elvl_old = (32'(lvl_rd) >= 32'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1) : lvl_rd;
      drop     = (32'(elvl_old) < 32'(NUM_LEVELS - 1)) &&
                 ({{(SVC_W-1){1'b0}}, 1'b1} << elvl_old) <= erun_sum;
      if (!eseen) begin
         elvl_new = '0;
         erun_new = '0;
      end else if (drop) begin
         elvl_new = elvl_old + LW'(1);
         erun_new = '0;
      end else begin
         elvl_new = elvl_old;
         erun_new = erun_sum;
      end
      eq = QW'(32'(elvl_new) * NUM_CLASSES + 32'(ecls));
   end

   // The tail port serves the selected list at accept and the enqueue's list in the READ state.
   assign tail_addr  = (state_ff == ST_IDLE) ? first_q : eq;
   assign tail_rd_en = accept || (state_ff == ST_READ && cur_ff.action == ACT_ENQUEUE);

   always_ff @(posedge clock) begin
      if (accept) begin
         run_rd  <= run_mem[slot_r];
         last_rd <= last_mem[slot_r];
         lvl_rd  <= lvl_mem[slot_r];
         head_rd <= head_mem[first_q];
      end
      if (tail_rd_en)
         tail_rd <= tail_mem[tail_addr];
      if (state_ff == ST_READ && cur_ff.action == ACT_SELECT)
         link_rd <= link_mem[head_rd];
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      sq_in     = sq_ff;
      sl_in     = sl_ff;
      sc_in     = sc_ff;
      seen_in   = seen_ff;
      queued_in = queued_ff;
      ne_in     = ne_ff;
      rv_in     = rv_ff;
      rsp_in    = rsp_ff;
      if (rv_ff && rsp.ready)
         rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in   = req.payload;
               sq_in    = first_q;
               sl_in    = first_lvl;
               sc_in    = first_cls;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
            if (cur_ff.action == ACT_ENQUEUE) begin
               if (ego) begin
                  seen_in[eslot]   = 1'b1;
                  queued_in[eslot] = 1'b1;
                  ne_in[eq]        = 1'b1;
               end
            end else begin
               rv_in  = 1'b1;
               rsp_in = '0;
               if (ne_ff[sq_ff]) begin
                  queued_in[head_rd]     = 1'b0;
                  if (head_rd == tail_rd)
                     ne_in[sq_ff] = 1'b0;
                  rsp_in.found           = 1'b1;
                  rsp_in.chosen_thread   = TID_W'(head_rd);
                  rsp_in.chosen_level    = LVLO_W'(sl_ff);
                  rsp_in.chosen_priority = PRIO_W'(sc_ff);
                  rsp_in.slice_ticks     = SLICE_W'(32'd1 << sl_ff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory write-back in the last cycle of an item. The link of a list's tail
   // is only followed once another slot is appended behind it.
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         if (cur_ff.action == ACT_ENQUEUE) begin
            if (ego) begin
               run_mem[eslot]  <= erun_new;
               last_mem[eslot] <= cur_ff.svc_ticks;
               lvl_mem[eslot]  <= elvl_new;
               tail_mem[eq]    <= eslot;
               if (ne_ff[eq])
                  link_mem[tail_rd] <= eslot;
               else
                  head_mem[eq] <= eslot;
            end
         end else if (ne_ff[sq_ff] && head_rd != tail_rd) begin
            head_mem[sq_ff] <= link_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seen_ff   <= '0;
         queued_ff <= '0;
         ne_ff     <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         queued_ff <= queued_in;
         ne_ff     <= ne_in;
         rv_ff     <= rv_in;
      end
      cur_ff <= cur_in;
      sq_ff  <= sq_in;
      sl_ff  <= sl_in;
      sc_ff  <= sc_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/mfq_checker.sv =====
// Port-level checker for the multilevel feedback queue, with its bind.
// Depends on mfq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mfq_checker import mfq_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     req_valid,
   input wire     req_ready,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input rsp_type rsp_payload
);
   `MFQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `MFQ_ASSERT(a_ready_gap, clock, reset, req_valid && req_ready |=> !req_ready)
   `MFQ_ASSERT(a_empty_zero, clock, reset, rsp_valid && !rsp_payload.found |-> rsp_payload.slice_ticks == '0)
   `MFQ_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid)
endmodule

bind multilevel_feedback_queue mfq_checker u_mfq_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire
